[rtl/icms_pkg.sv]
// Package with shared widths, limits and types of the merge sort inversion counter.
`default_nettype none
package icms_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 19;
    localparam int ITEM_W  = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 19'h7FFFF;
    localparam logic [ITEM_W-1:0]  ITEMS_MAX = 11'h7FF;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_READ = 5'b00100,
        S_CMP  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

endpackage
`default_nettype wire

[rtl/icms_bank.sv]
// Value memory with one write port and two registered read ports.
`default_nettype none
module icms_bank #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire  [AW-1:0]                i_wa,
    input  wire  [icms_pkg::VALUE_W-1:0] i_wd,
    input  wire  [AW-1:0]                i_ra,
    input  wire  [AW-1:0]                i_rb,
    output logic [icms_pkg::VALUE_W-1:0] o_da,
    output logic [icms_pkg::VALUE_W-1:0] o_db
);
    import icms_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_da <= r_mem[i_ra];
        o_db <= r_mem[i_rb];
    end

endmodule
`default_nettype wire

[rtl/icms_merge.sv]
// Merge sequencer with the shared compare unit and the inversion accumulator.
`default_nettype none
module icms_merge #(
    parameter int AW        = 10,
    parameter int IW        = 11
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_go,
    input  wire  [IW-1:0]                i_n,
    output logic [AW-1:0]                o_ra,
    output logic [AW-1:0]                o_rb,
    input  wire  [icms_pkg::VALUE_W-1:0] i_da,
    input  wire  [icms_pkg::VALUE_W-1:0] i_db,
    output logic                         o_src,
    output logic                         o_we,
    output logic                         o_wsel,
    output logic [AW-1:0]                o_wa,
    output logic [icms_pkg::VALUE_W-1:0] o_wd,
    output icms_pkg::t_eng_stat          o_stat,
    output logic [icms_pkg::COUNT_W-1:0] o_count
);
    import icms_pkg::*;

    localparam int RW = IW + 2;
    localparam int SW = ((IW > COUNT_W) ? IW : COUNT_W) + 1;

    t_state             r_state;
    t_state             n_state;
    logic [IW-1:0]      r_n;
    logic [RW-1:0]      r_w;
    logic [RW-1:0]      r_lo;
    logic [IW-1:0]      r_mid;
    logic [IW-1:0]      r_hi;
    logic [IW-1:0]      r_a;
    logic [IW-1:0]      r_b;
    logic [IW-1:0]      r_k;
    logic               r_src;
    logic [COUNT_W-1:0] r_cnt;

    logic [RW-1:0]      w_n_ext;
    logic [RW-1:0]      w_mid_raw;
    logic [RW-1:0]      w_hi_raw;
    logic [RW-1:0]      w_w2;
    logic [IW-1:0]      w_mid;
    logic [IW-1:0]      w_hi;
    logic               w_left;
    logic               w_right;
    logic               w_take_right;
    logic [IW-1:0]      w_add;
    logic [SW-1:0]      w_sum;
    logic [COUNT_W-1:0] w_cnt_next;
    logic               w_run_end;

    assign w_n_ext   = RW'(r_n);
    assign w_w2      = r_w << 1;
    assign w_mid_raw = r_lo + r_w;
    assign w_hi_raw  = r_lo + w_w2;
    assign w_mid     = (w_mid_raw > w_n_ext) ? r_n : IW'(w_mid_raw);
    assign w_hi      = (w_hi_raw > w_n_ext) ? r_n : IW'(w_hi_raw);

    assign w_left       = r_a < r_mid;
    assign w_right      = r_b < r_hi;
    assign w_take_right = w_right && (!w_left || ($signed(i_da) > $signed(i_db)));
    assign w_add        = r_mid - r_a;
    assign w_sum        = SW'(r_cnt) + SW'(w_add);
    assign w_cnt_next   = (w_sum > SW'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(w_sum);
    assign w_run_end    = (r_k + IW'(1)) == r_hi;

    assign o_ra    = r_a[AW-1:0];
    assign o_rb    = r_b[AW-1:0];
    assign o_src   = r_src;
    assign o_we    = (r_state == S_CMP);
    assign o_wsel  = ~r_src;
    assign o_wa    = r_k[AW-1:0];
    assign o_wd    = w_take_right ? i_db : i_da;
    assign o_count = r_cnt;
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = (i_n > IW'(1)) ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                if (r_lo >= w_n_ext) begin
                    n_state = (w_w2 >= w_n_ext) ? S_DONE : S_RUN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP:  n_state = w_run_end ? S_RUN : S_READ;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    r_n   <= i_n;
                    r_cnt <= '0;
                    r_w   <= RW'(1);
                    r_lo  <= '0;
                    r_src <= 1'b0;
                end
            end
            S_RUN: begin
                if (r_lo >= w_n_ext) begin
                    r_w   <= w_w2;
                    r_lo  <= '0;
                    r_src <= ~r_src;
                end else begin
                    r_mid <= w_mid;
                    r_hi  <= w_hi;
                    r_a   <= IW'(r_lo);
                    r_b   <= w_mid;
                    r_k   <= IW'(r_lo);
                end
            end
            S_CMP: begin
                if (w_take_right) begin
                    r_b <= r_b + IW'(1);
                    if (w_left) begin
                        r_cnt <= w_cnt_next;
                    end
                end else begin
                    r_a <= r_a + IW'(1);
                end
                r_k <= r_k + IW'(1);
                if (w_run_end) begin
                    r_lo <= w_hi_raw;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/inversion_counter_merge_sort.sv]
// Top level of the merge sort inversion counter: loading, memories and result register.
// The block takes one value per cycle while busy is low; a transaction with last set closes
// the sequence, and values beyond MAX_ITEMS are dropped and reported as overflow. After the
// closing transaction busy stays high while a bottom-up merge sort counts the inversions,
// taking each element through a read state and then a compare state in a single compare
// unit behind registered memory reads. The result is shown for exactly one cycle with
// o_valid high and cannot be held off, so the receiver must take it then; the count
// saturates at its field's maximum.
`default_nettype none
module inversion_counter_merge_sort #(
    parameter int MAX_ITEMS = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [icms_pkg::VALUE_W-1:0] i_value,
    input  wire                          i_last,
    output logic                         o_valid,
    output logic [icms_pkg::COUNT_W-1:0] o_inversion_count,
    output logic [icms_pkg::ITEM_W-1:0]  o_item_count,
    output logic                         o_overflow
);
    import icms_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int XW = (IW > ITEM_W) ? IW : ITEM_W;

    logic [IW-1:0]      r_n;
    logic               r_drop;
    logic               r_go;

    logic               w_accept;
    logic               w_load_we;
    logic [XW-1:0]      w_n_ext;
    logic [AW-1:0]      w_ra;
    logic [AW-1:0]      w_rb;
    logic [VALUE_W-1:0] w_da0;
    logic [VALUE_W-1:0] w_db0;
    logic [VALUE_W-1:0] w_da1;
    logic [VALUE_W-1:0] w_db1;
    logic               w_src;
    logic               w_eng_we;
    logic               w_wsel;
    logic [AW-1:0]      w_eng_wa;
    logic [VALUE_W-1:0] w_eng_wd;
    t_eng_stat          w_stat;
    logic [COUNT_W-1:0] w_count;
    logic               w_we0;
    logic [AW-1:0]      w_wa0;
    logic [VALUE_W-1:0] w_wd0;

    assign busy      = r_go | w_stat.busy;
    assign w_accept  = start & ~busy;
    assign w_load_we = w_accept && (r_n < IW'(MAX_ITEMS));
    assign w_n_ext   = XW'(r_n);

    assign w_we0 = w_load_we | (w_eng_we & ~w_wsel);
    assign w_wa0 = w_load_we ? r_n[AW-1:0] : w_eng_wa;
    assign w_wd0 = w_load_we ? i_value : w_eng_wd;

    icms_bank #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_bank0 (
        .i_clk (i_clk),
        .i_we  (w_we0),
        .i_wa  (w_wa0),
        .i_wd  (w_wd0),
        .i_ra  (w_ra),
        .i_rb  (w_rb),
        .o_da  (w_da0),
        .o_db  (w_db0)
    );

    icms_bank #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_bank1 (
        .i_clk (i_clk),
        .i_we  (w_eng_we & w_wsel),
        .i_wa  (w_eng_wa),
        .i_wd  (w_eng_wd),
        .i_ra  (w_ra),
        .i_rb  (w_rb),
        .o_da  (w_da1),
        .o_db  (w_db1)
    );

    icms_merge #(
        .AW        (AW),
        .IW        (IW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_n     (r_n),
        .o_ra    (w_ra),
        .o_rb    (w_rb),
        .i_da    (w_src ? w_da1 : w_da0),
        .i_db    (w_src ? w_db1 : w_db0),
        .o_src   (w_src),
        .o_we    (w_eng_we),
        .o_wsel  (w_wsel),
        .o_wa    (w_eng_wa),
        .o_wd    (w_eng_wd),
        .o_stat  (w_stat),
        .o_count (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= '0;
            r_drop  <= 1'b0;
            r_go    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_go    <= w_accept & i_last;
            o_valid <= w_stat.done;
            if (w_accept) begin
                if (w_load_we) begin
                    r_n <= r_n + IW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (w_stat.done) begin
                r_n    <= '0;
                r_drop <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            o_inversion_count <= w_count;
            o_item_count      <= (w_n_ext > XW'(ITEMS_MAX)) ? ITEMS_MAX : ITEM_W'(w_n_ext);
            o_overflow        <= r_drop;
        end
    end

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the merge sort inversion counter with a pairwise-count predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import icms_pkg::*;

    localparam int MAX_ITEMS = 1024;
    localparam int SHORT_ITEMS = 450;
    localparam int LONG_ITEMS = 300;

    typedef struct packed {
        logic [COUNT_W-1:0] inversions;
        logic [ITEM_W-1:0]  items;
        logic               overflow;
    } t_tally;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               typed;
        logic [COUNT_W-1:0] inversions;
        logic [ITEM_W-1:0]  items;
        logic               overflow;
    } t_row;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_TIES,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_EXTREMES
    } t_shape;

    localparam int N_DIRECTED = 19;
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        {32'h7FFF_FFFF, 1'b1, 1'b1, 19'd0, 11'd1, 1'b0},
        {32'h8000_0000, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h7FFF_FFFF, 1'b1, 1'b1, 19'd0, 11'd2, 1'b0},
        {32'h7FFF_FFFF, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h8000_0000, 1'b1, 1'b1, 19'd1, 11'd2, 1'b0},
        {32'h0000_0005, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h0000_0005, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h0000_0005, 1'b1, 1'b1, 19'd0, 11'd3, 1'b0},
        {32'h0000_0003, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h0000_0002, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h0000_0001, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'hFFFF_FFFF, 1'b1, 1'b1, 19'd6, 11'd4, 1'b0},
        {32'hAAAA_AAAA, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h5555_5555, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h0000_0000, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'hFFFF_FFFF, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h8000_0000, 1'b0, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h7FFF_FFFF, 1'b1, 1'b0, 19'd0, 11'd0, 1'b0},
        {32'h0000_0000, 1'b1, 1'b1, 19'd0, 11'd1, 1'b0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [VALUE_W-1:0] i_value;
    logic               i_last;
    logic               o_valid;
    logic [COUNT_W-1:0] o_inversion_count;
    logic [ITEM_W-1:0]  o_item_count;
    logic               o_overflow;

    logic signed [VALUE_W-1:0] held_values[$];
    logic                      held_overflow;
    t_tally                    pending_tallies[$];
    int                        error_count;

    inversion_counter_merge_sort #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_value          (i_value),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .o_inversion_count(o_inversion_count),
        .o_item_count     (o_item_count),
        .o_overflow       (o_overflow)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic flag_error(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    function automatic t_tally tally_held();
        t_tally     result;
        longint     pairs;
        int         held;
        pairs = 0;
        held = held_values.size();
        for (int i = 0; i < held; i++) begin
            for (int j = i + 1; j < held; j++) begin
                if (held_values[i] > held_values[j]) begin
                    pairs++;
                end
            end
        end
        result.inversions = (pairs > longint'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(pairs);
        result.items = (held > int'(ITEMS_MAX)) ? ITEMS_MAX : ITEM_W'(held);
        result.overflow = held_overflow;
        return result;
    endfunction

    task automatic absorb_element(input logic [VALUE_W-1:0] value, input logic is_last,
                                  input logic typed, input t_tally typed_tally);
        if (held_values.size() < MAX_ITEMS) begin
            held_values.push_back(value);
        end else begin
            held_overflow = 1'b1;
        end
        if (is_last) begin
            pending_tallies.push_back(typed ? typed_tally : tally_held());
            held_values.delete();
            held_overflow = 1'b0;
        end
    endtask

    // Entered and left at a falling edge; start stays high on exit so back-to-back
    // transactions need no second assignment within one time step.
    task automatic feed_element(input logic [VALUE_W-1:0] value, input logic is_last,
                                input logic typed, input t_tally typed_tally, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        i_last  <= is_last;
        do @(posedge i_clk); while (busy);
        absorb_element(value, is_last, typed, typed_tally);
        @(negedge i_clk);
    endtask

    task automatic wait_for_tallies();
        start <= 1'b0;
        while (pending_tallies.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input t_shape shape, input int k);
        case (shape)
            SHAPE_TIES:    return VALUE_W'($urandom_range(0, 6) - 3);
            SHAPE_RISING:  return VALUE_W'(k * 37 - 1000);
            SHAPE_FALLING: return VALUE_W'(1000 - k * 37);
            SHAPE_EXTREMES: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:       return $urandom;
        endcase
    endfunction

    task automatic feed_sequence(input int length, input t_shape shape, input bit burst);
        t_tally none;
        none = '0;
        for (int k = 0; k < length; k++) begin
            feed_element(pick_value(shape, k), k == length - 1, 1'b0, none,
                         burst ? 0 : $urandom_range(0, 12));
        end
    endtask

    always @(posedge i_clk) begin
        t_tally want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_tallies.size() == 0) begin
                flag_error($sformatf("result with nothing expected: count %0d items %0d ovf %0b",
                                     o_inversion_count, o_item_count, o_overflow));
            end else begin
                want = pending_tallies.pop_front();
                if (o_inversion_count !== want.inversions) begin
                    flag_error($sformatf("inversion_count %0d, expected %0d",
                                         o_inversion_count, want.inversions));
                end
                if (o_item_count !== want.items) begin
                    flag_error($sformatf("item_count %0d, expected %0d",
                                         o_item_count, want.items));
                end
                if (o_overflow !== want.overflow) begin
                    flag_error($sformatf("overflow %0b, expected %0b",
                                         o_overflow, want.overflow));
                end
            end
        end
    end

    initial begin
        t_tally  typed_tally;
        t_tally  none;
        t_row    row;
        int      short_fed;
        int      seq_index;
        int      length;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_value       = '0;
        i_last        = 1'b0;
        held_overflow = 1'b0;
        error_count   = 0;
        none          = '0;
        short_fed     = 0;
        seq_index     = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            typed_tally = {row.inversions, row.items, row.overflow};
            feed_element(row.value, row.last, row.typed, typed_tally, $urandom_range(0, 12));
        end
        wait_for_tallies();
        @(negedge i_clk);

        while (short_fed < SHORT_ITEMS) begin
            if (seq_index == 6) begin
                feed_sequence(LONG_ITEMS, SHAPE_RANDOM, 1'($urandom_range(0, 1)));
            end else if (seq_index == 18) begin
                typed_tally = {19'd523776, 11'd1024, 1'b1};
                for (int k = 0; k < MAX_ITEMS + 3; k++) begin
                    feed_element(32'h7FFF_FFFF - k, k == MAX_ITEMS + 2, 1'b1, typed_tally,
                                 $urandom_range(0, 3));
                end
            end else begin
                length = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
                feed_sequence(length, t_shape'($urandom_range(0, 4)),
                              $urandom_range(0, 3) == 0);
                short_fed += length;
            end
            seq_index++;
            if ($urandom_range(0, 5) == 0) begin
                wait_for_tallies();
                @(negedge i_clk);
            end
        end

        wait_for_tallies();
        repeat (64) @(negedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
